[sv/pbr_pkg.sv]
// Shared types, constants and a helper function for the PCM bias removal ring buffer.
// Used by the controller, the datapath, the top level and the checker.
package pbr_pkg;

    // Ring geometry. The ring holds RING_DEPTH-1 samples.
    localparam int RING_DEPTH = 512;
    localparam int PTR_W      = $clog2(RING_DEPTH);

    // Fixed field widths.
    localparam int KIND_W  = 2;
    localparam int ADC_W   = 12;
    localparam int PCM_W   = 16;
    localparam int OCC_W   = 9;
    localparam int BIAS_W  = 12;
    localparam int SUM_W   = 19;
    localparam int COUNT_W = 7;
    localparam int GAIN_SHIFT = 4;

    // Width used for the occupancy subtraction, wide enough for both pointers and the report.
    localparam int FILL_W = (PTR_W + 1 > OCC_W) ? PTR_W + 1 : OCC_W;

    // Calibration round length and its reciprocal: floor(x/100) = (x * RECIP) >> RECIP_SHIFT
    // holds for every 19-bit x.
    localparam int CAL_ROUND   = 100;
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP_W     = 20;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(671089);
    localparam int PROD_W      = SUM_W + RECIP_W;

    // Item kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_CAL    = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_READ   = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic exec;
        logic div_mul;
        logic div_apply;
        logic load_out;
    } pbr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic round_done;
        logic out_free;
    } pbr_status_t;

    // Advance a ring pointer with wraparound at any depth.
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(RING_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

endpackage

[sv/pbr_ctrl.sv]
// Controller state machine for the PCM bias removal ring buffer.
// Depends on pbr_pkg for the command and status types.
module pbr_ctrl
    import pbr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  pbr_status_t status,
    output pbr_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_BIAS,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state: one item in flight, with an extra multiply and apply step at the end of a round.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = status.round_done ? S_DIV : S_RESULT;
            end
            S_DIV:
            begin
                state_next = S_BIAS;
            end
            S_BIAS:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Commands decoded from the state.
    always_comb
    begin
        cmd           = '0;
        cmd.load_item = (state_reg == S_IDLE) && in_valid;
        cmd.exec      = (state_reg == S_EXEC);
        cmd.div_mul   = (state_reg == S_DIV);
        cmd.div_apply = (state_reg == S_BIAS);
        cmd.load_out  = (state_reg == S_RESULT) && status.out_free;
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

[sv/pbr_datapath.sv]
// Datapath for the PCM bias removal ring buffer: sample ring, pointers,
// calibration accumulator with reciprocal divider, and the result register. Depends on pbr_pkg.
module pbr_datapath
    import pbr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  pbr_cmd_t                 cmd,
    output pbr_status_t              status,
    input  logic [KIND_W-1:0]        kind,
    input  logic [ADC_W-1:0]         adc_value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     ok,
    output logic signed [PCM_W-1:0]  pcm_sample,
    output logic [OCC_W-1:0]         occupancy,
    output logic [BIAS_W-1:0]        bias_value
);

    // Sample ring; read data is only used when the ring was not empty.
    logic [PCM_W-1:0] ring_mem [RING_DEPTH];

    // Item registers.
    logic [KIND_W-1:0]  kind_reg;
    logic [ADC_W-1:0]   adc_reg;

    // Control state.
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [BIAS_W-1:0]  bias_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               ok_reg;
    logic               rd_hit_reg;
    logic               out_valid_reg;

    // Payload registers.
    logic [PCM_W-1:0]   rd_data_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               ok_out_reg;
    logic [PCM_W-1:0]   pcm_out_reg;
    logic [OCC_W-1:0]   occ_out_reg;
    logic [BIAS_W-1:0]  bias_out_reg;

    logic               ring_full;
    logic               ring_empty;
    logic [ADC_W-1:0]   diff;
    logic [PCM_W-1:0]   pcm_in;
    logic [FILL_W-1:0]  fill;
    logic               do_write;

    // Ring status and the scaled insert value, (adc - bias) * 16 wrapped to 16 bits.
    assign ring_full  = (ptr_inc(wr_ptr_reg) == rd_ptr_reg);
    assign ring_empty = (wr_ptr_reg == rd_ptr_reg);
    assign diff       = adc_reg - bias_reg;
    assign pcm_in     = {diff, {GAIN_SHIFT{1'b0}}};
    assign do_write   = cmd.exec && (kind_reg == KIND_INSERT) && !ring_full;

    // Occupancy, wrapped at the ring depth and reported modulo 512.
    always_comb
    begin
        if (wr_ptr_reg >= rd_ptr_reg)
        begin
            fill = FILL_W'(wr_ptr_reg) - FILL_W'(rd_ptr_reg);
        end
        else
        begin
            fill = FILL_W'(wr_ptr_reg) + FILL_W'(RING_DEPTH) - FILL_W'(rd_ptr_reg);
        end
    end

    assign status.round_done = (kind_reg == KIND_CAL) && (count_reg == COUNT_W'(CAL_ROUND - 1));
    assign status.out_free   = !out_valid_reg || !out_stall;

    // Ring memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            ring_mem[wr_ptr_reg] <= pcm_in;
        end
        if (cmd.exec)
        begin
            rd_data_reg <= ring_mem[rd_ptr_reg];
        end
    end

    // Item capture, reciprocal product and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg <= kind;
            adc_reg  <= adc_value;
        end
        if (cmd.div_mul)
        begin
            prod_reg <= PROD_W'(sum_reg) * PROD_W'(RECIP);
        end
        if (cmd.load_out)
        begin
            ok_out_reg   <= ok_reg;
            pcm_out_reg  <= rd_hit_reg ? rd_data_reg : '0;
            occ_out_reg  <= fill[OCC_W-1:0];
            bias_out_reg <= bias_reg;
        end
    end

    // Pointers, calibration accumulator, bias and per-item flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            bias_reg   <= '0;
            sum_reg    <= '0;
            count_reg  <= '0;
            ok_reg     <= 1'b0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                case (kind_reg)
                    KIND_CAL:
                    begin
                        sum_reg    <= sum_reg + SUM_W'(adc_reg);
                        count_reg  <= status.round_done ? '0 : count_reg + COUNT_W'(1);
                        ok_reg     <= 1'b1;
                        rd_hit_reg <= 1'b0;
                    end
                    KIND_INSERT:
                    begin
                        if (!ring_full)
                        begin
                            wr_ptr_reg <= ptr_inc(wr_ptr_reg);
                        end
                        ok_reg     <= !ring_full;
                        rd_hit_reg <= 1'b0;
                    end
                    KIND_READ:
                    begin
                        if (!ring_empty)
                        begin
                            rd_ptr_reg <= ptr_inc(rd_ptr_reg);
                        end
                        ok_reg     <= !ring_empty;
                        rd_hit_reg <= !ring_empty;
                    end
                    default:
                    begin
                        ok_reg     <= 1'b0;
                        rd_hit_reg <= 1'b0;
                    end
                endcase
            end
            // Close the round: bias = floor(sum / 100), then restart the sum.
            if (cmd.div_apply)
            begin
                bias_reg <= prod_reg[RECIP_SHIFT +: BIAS_W];
                sum_reg  <= '0;
            end
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign ok         = ok_out_reg;
    assign pcm_sample = $signed(pcm_out_reg);
    assign occupancy  = occ_out_reg;
    assign bias_value = bias_out_reg;

endmodule

[sv/pcm_bias_removal_ring_buffer.sv]
// Top level of the PCM bias removal ring buffer: controller plus datapath.
// Depends on pbr_pkg, pbr_ctrl and pbr_datapath.
// Sequence: an item is captured, then executed (S_EXEC), then loaded as a result (S_RESULT);
// an item that closes a calibration round also passes multiply (S_DIV) and apply (S_BIAS) first.
// One item is in flight: no new item is taken until the last is loaded, also while a result stalls.
// Reset: asynchronous, active low; pointers, bias and calibration state clear, ring contents do not.
module pcm_bias_removal_ring_buffer
    import pbr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [KIND_W-1:0]        kind,
    input  logic [ADC_W-1:0]         adc_value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     ok,
    output logic signed [PCM_W-1:0]  pcm_sample,
    output logic [OCC_W-1:0]         occupancy,
    output logic [BIAS_W-1:0]        bias_value
);

    pbr_cmd_t    cmd;
    pbr_status_t status;

    // Sequencing of each item.
    pbr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Storage, arithmetic and result register.
    pbr_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .kind       (kind),
        .adc_value  (adc_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ok         (ok),
        .pcm_sample (pcm_sample),
        .occupancy  (occupancy),
        .bias_value (bias_value)
    );

endmodule

[sv/pbr_checker.sv]
// Port-level checker for the PCM bias removal ring buffer, bound to the top level.
// Depends on pbr_pkg for widths and the ring depth.
module pbr_checker
    import pbr_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic [KIND_W-1:0]        kind,
    input logic [ADC_W-1:0]         adc_value,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic                     ok,
    input logic signed [PCM_W-1:0]  pcm_sample,
    input logic [OCC_W-1:0]         occupancy,
    input logic [BIAS_W-1:0]        bias_value
);

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(ok) && $stable(pcm_sample)
            && $stable(occupancy) && $stable(bias_value))
        else $error("stalled result changed");

    // After an input transfer the block holds off the next item.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken while one is in flight");

    // A failed item never carries a sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> pcm_sample == '0)
        else $error("sample reported without a successful read");

    // The ring never reports more than its capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (RING_DEPTH > 512) || (int'(occupancy) < RING_DEPTH))
        else $error("occupancy beyond ring capacity");

endmodule

bind pcm_bias_removal_ring_buffer pbr_checker u_pbr_checker (.*);

[tb/tb_top.sv]
// Self-checking testbench for the PCM bias removal ring buffer.
// Depends on pbr_pkg and pcm_bias_removal_ring_buffer, which needs pbr_ctrl and pbr_datapath.
// The bench drives calibration, insert and read transfers, predicts every result and checks them.
module tb_top;
    import pbr_pkg::*;

    localparam int PCM_GAIN     = 16;
    localparam int RESET_CYCLES = 12;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PAUSE_AT     = 650;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_LEN     = 400;
    localparam int TOTAL_ITEMS  = 1050;
    localparam int MAX_PRINTS   = 40;

    typedef struct {
        kind_t            k;
        logic [ADC_W-1:0] adc;
    } mic_item_t;

    typedef struct {
        logic                    ok;
        logic signed [PCM_W-1:0] pcm;
        logic [OCC_W-1:0]        occ;
        logic [BIAS_W-1:0]       bias;
    } pcm_result_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [KIND_W-1:0]       kind;
    logic [ADC_W-1:0]        adc_value;
    logic                    out_valid;
    logic                    out_stall;
    logic                    ok;
    logic signed [PCM_W-1:0] pcm_sample;
    logic [OCC_W-1:0]        occupancy;
    logic [BIAS_W-1:0]       bias_value;

    // Stimulus waiting to be offered and results waiting to arrive.
    mic_item_t   mic_items[$];
    pcm_result_t pending_results[$];

    // Shadow copy of the front end state.
    logic [PCM_W-1:0]   ring_shadow [RING_DEPTH];
    logic [PTR_W-1:0]   wr_ptr;
    logic [PTR_W-1:0]   rd_ptr;
    logic [BIAS_W-1:0]  bias_shadow;
    logic [SUM_W-1:0]   cal_sum;
    logic [COUNT_W-1:0] cal_count;

    int  n_sent;
    int  n_checked;
    int  n_errors;
    int  cycle_count;
    int  n_total;
    bit  pause_done;
    logic long_hold;
    int  hold_cnt;
    bit  hold_done;

    pcm_bias_removal_ring_buffer i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .adc_value  (adc_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ok         (ok),
        .pcm_sample (pcm_sample),
        .occupancy  (occupancy),
        .bias_value (bias_value)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Apply one item to the shadow state and return the result it should produce.
    function automatic pcm_result_t predict_pcm_result(input kind_t k, input logic [ADC_W-1:0] adc);
        pcm_result_t      r;
        logic [PTR_W-1:0] nxt;
        r.ok  = 1'b0;
        r.pcm = '0;
        case (k)
            KIND_CAL:
            begin
                cal_sum   = SUM_W'(cal_sum + adc);
                cal_count = cal_count + 1'b1;
                if (cal_count >= CAL_ROUND)
                begin
                    bias_shadow = BIAS_W'(cal_sum / CAL_ROUND);
                    cal_sum     = '0;
                    cal_count   = '0;
                end
                r.ok = 1'b1;
            end
            KIND_INSERT:
            begin
                nxt = PTR_W'((int'(wr_ptr) + 1) % RING_DEPTH);
                if (nxt != rd_ptr)
                begin
                    ring_shadow[wr_ptr] = PCM_W'((int'(adc) - int'(bias_shadow)) * PCM_GAIN);
                    wr_ptr = nxt;
                    r.ok   = 1'b1;
                end
            end
            KIND_READ:
            begin
                if (wr_ptr != rd_ptr)
                begin
                    r.pcm  = ring_shadow[rd_ptr];
                    rd_ptr = PTR_W'((int'(rd_ptr) + 1) % RING_DEPTH);
                    r.ok   = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.occ  = OCC_W'((int'(wr_ptr) + RING_DEPTH - int'(rd_ptr)) % RING_DEPTH);
        r.bias = bias_shadow;
        return r;
    endfunction

    // Print one line per mismatch, up to a cap, and count them all.
    task automatic report_mismatch(input string what, input int got, input int want);
        if (n_errors < MAX_PRINTS)
        begin
            $display("mismatch at result %0d: %s got %0d expected %0d", n_checked, what, got,
                     want);
        end
        n_errors++;
    endtask

    task automatic add_item(input kind_t k, input logic [ADC_W-1:0] adc);
        mic_item_t it;
        it.k   = k;
        it.adc = adc;
        mic_items.push_back(it);
    endtask

    // Mostly random converter values, with the extremes now and then.
    function automatic logic [ADC_W-1:0] pick_adc();
        logic [ADC_W-1:0] a;
        case ($urandom_range(9))
            0: a = '0;
            1: a = '1;
            default: a = ADC_W'($urandom_range(4095));
        endcase
        return a;
    endfunction

    // Weighted choice of kind for the mixed traffic.
    function automatic kind_t pick_kind();
        int    r;
        kind_t k;
        r = $urandom_range(99);
        if (r < 20)
            k = KIND_CAL;
        else if (r < 60)
            k = KIND_INSERT;
        else if (r < 95)
            k = KIND_READ;
        else
            k = KIND_NONE;
        return k;
    endfunction

    // Idling phase, stepped by the cycle counter: none, sender, receiver, both.
    function automatic bit sender_idles();
        bit idle;
        case ((cycle_count / 1024) % 4)
            1: idle = ($urandom_range(99) < 70);
            3: idle = ($urandom_range(99) < 25);
            default: idle = 1'b0;
        endcase
        return idle;
    endfunction

    function automatic bit receiver_stalls();
        bit st;
        case ((cycle_count / 1024) % 4)
            2: st = ($urandom_range(99) < 70);
            3: st = ($urandom_range(99) < 25);
            default: st = 1'b0;
        endcase
        return st;
    endfunction

    // Stimulus, reset and end of run.
    initial
    begin
        int cals;
        rst_n       = 1'b0;
        wr_ptr      = '0;
        rd_ptr      = '0;
        bias_shadow = '0;
        cal_sum     = '0;
        cal_count   = '0;
        n_sent      = 0;
        n_errors    = 0;
        pause_done  = 1'b0;

        // Directed: empty read, unknown kind, field extremes, drain to empty again.
        add_item(KIND_READ, '0);
        add_item(KIND_NONE, '1);
        add_item(KIND_NONE, '0);
        add_item(KIND_CAL, '0);
        add_item(KIND_CAL, '1);
        add_item(KIND_INSERT, '0);
        add_item(KIND_INSERT, '1);
        add_item(KIND_INSERT, 12'h800);
        add_item(KIND_INSERT, 12'h555);
        add_item(KIND_INSERT, 12'hAAA);
        add_item(KIND_READ, '1);
        add_item(KIND_READ, 12'h555);
        add_item(KIND_READ, '0);
        add_item(KIND_READ, 12'hAAA);
        add_item(KIND_READ, '0);
        add_item(KIND_READ, '0);
        add_item(KIND_INSERT, 12'h7FF);
        add_item(KIND_NONE, 12'h7FF);
        add_item(KIND_READ, '0);

        // Finish the first calibration round amid random traffic.
        cals = 2;
        while (cals < CAL_ROUND)
        begin
            if ($urandom_range(99) < 70)
            begin
                add_item(KIND_CAL, pick_adc());
                cals++;
            end
            else
            begin
                add_item(($urandom_range(1) == 0) ? KIND_INSERT : KIND_READ, pick_adc());
            end
        end

        // Fill the ring past full so that samples get dropped.
        repeat (530)
        begin
            add_item(($urandom_range(99) < 3) ? KIND_NONE : KIND_INSERT, pick_adc());
        end

        // A round of full-scale samples drives the bias to its top value.
        repeat (CAL_ROUND)
        begin
            add_item(KIND_CAL, '1);
        end

        // Drain with some inserts, which now wrap below zero.
        repeat (120)
        begin
            add_item(($urandom_range(99) < 70) ? KIND_READ : KIND_INSERT, pick_adc());
        end

        // Mixed random traffic for the rest.
        while (mic_items.size() < TOTAL_ITEMS)
        begin
            add_item(pick_kind(), pick_adc());
        end
        n_total = mic_items.size();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (!(n_sent == n_total && n_checked == n_sent))
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            report_mismatch("results never arrived", 0, pending_results.size());
        end

        if (n_errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Driver: offer queued items; predict each one at its transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            kind      <= KIND_CAL;
            adc_value <= '0;
        end
        else
        begin
            bit xfer;
            bit hold_back;
            xfer = in_valid && !in_stall;
            if (xfer)
            begin
                pending_results.push_back(predict_pcm_result(kind_t'(kind), adc_value));
                n_sent++;
            end
            // Once, let every outstanding result come back before going on.
            hold_back = 1'b0;
            if (n_sent == PAUSE_AT && !pause_done)
            begin
                if (n_checked == n_sent)
                    pause_done = 1'b1;
                else
                    hold_back = 1'b1;
            end
            if (!in_valid || xfer)
            begin
                if (mic_items.size() != 0 && !hold_back && !sender_idles())
                begin
                    in_valid  <= 1'b1;
                    kind      <= mic_items[0].k;
                    adc_value <= mic_items[0].adc;
                    mic_items.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transfer against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            n_checked <= 0;
        end
        else
        begin
            pcm_result_t want;
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("result with nothing expected", 1, 0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (ok !== want.ok)
                        report_mismatch("ok", ok, want.ok);
                    if (pcm_sample !== want.pcm)
                        report_mismatch("pcm_sample", pcm_sample, want.pcm);
                    if (occupancy !== want.occ)
                        report_mismatch("occupancy", occupancy, want.occ);
                    if (bias_value !== want.bias)
                        report_mismatch("bias_value", bias_value, want.bias);
                    n_checked <= n_checked + 1;
                end
            end
            out_stall <= long_hold || receiver_stalls();
        end
    end

    // One long receiver hold-off, so the block backs up and stalls its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_hold <= 1'b0;
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && n_checked >= HOLD_AT)
        begin
            if (hold_cnt == HOLD_LEN)
            begin
                long_hold <= 1'b0;
                hold_done <= 1'b1;
            end
            else
            begin
                long_hold <= 1'b1;
                hold_cnt  <= hold_cnt + 1;
            end
        end
    end

    // Cycle counter and run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        cycle_count = 0;
    end

endmodule
